FILE: design/cch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cch_pkg;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DECL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

	localparam logic signed [15:0] DECL_RESET   = 16'sd255;
	localparam logic [15:0]        WINDOW_RESET = 16'd5000;

	localparam logic signed [17:0] FULL_TURN   = 18'sd36000;
	localparam logic signed [31:0] HALF_TURN_Z = 32'sd1179648000;
	localparam logic signed [31:0] ROUND_HALF  = 32'sd32768;

	localparam logic [15:0] EDGE_N_HI = 16'd33750;
	localparam logic [15:0] EDGE_N_LO = 16'd2250;
	localparam logic [15:0] EDGE_NW   = 16'd29250;
	localparam logic [15:0] EDGE_W    = 16'd24750;
	localparam logic [15:0] EDGE_SW   = 16'd20250;
	localparam logic [15:0] EDGE_S    = 16'd15750;
	localparam logic [15:0] EDGE_SE   = 16'd11250;
	localparam logic [15:0] EDGE_E    = 16'd6750;

	localparam logic [2:0] SEC_N  = 3'd0;
	localparam logic [2:0] SEC_NE = 3'd1;
	localparam logic [2:0] SEC_E  = 3'd2;
	localparam logic [2:0] SEC_SE = 3'd3;
	localparam logic [2:0] SEC_S  = 3'd4;
	localparam logic [2:0] SEC_SW = 3'd5;
	localparam logic [2:0] SEC_W  = 3'd6;
	localparam logic [2:0] SEC_NW = 3'd7;

	typedef logic [2:0] step_t;
	localparam step_t ST_CAL  = 3'd0;
	localparam step_t ST_MID  = 3'd1;
	localparam step_t ST_VEC  = 3'd2;
	localparam step_t ST_PRE  = 3'd3;
	localparam step_t ST_ROT  = 3'd4;
	localparam step_t ST_RND  = 3'd5;
	localparam step_t ST_WRAP = 3'd6;
	localparam step_t ST_DONE = 3'd7;

	typedef enum logic [2:0] {
		OP_NOP, OP_CAL, OP_MID, OP_VEC, OP_PRE, OP_ROT, OP_RND, OP_WRAP
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT, C_ZERO, C_LOOP, C_RANGE, C_END
	} cond_t;

	typedef enum logic {
		SQ_IDLE, SQ_RUN
	} seq_state_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic vec_zero;
		logic iter_last;
		logic out_range;
	} status_t;

	typedef struct packed {
		logic [15:0] heading;
		logic [2:0]  sector;
		logic        lamp;
		logic        cal;
	} res_t;

	// Microprogram: one control word per step
	function automatic ctrl_t ucode(step_t s);
		ctrl_t cw;
		cw = '{op: OP_NOP, cond: C_END, target: ST_CAL};
		case (s)
			ST_CAL:  cw = '{op: OP_CAL,  cond: C_NEXT,  target: ST_CAL};
			ST_MID:  cw = '{op: OP_MID,  cond: C_NEXT,  target: ST_CAL};
			ST_VEC:  cw = '{op: OP_VEC,  cond: C_ZERO,  target: ST_RND};
			ST_PRE:  cw = '{op: OP_PRE,  cond: C_NEXT,  target: ST_CAL};
			ST_ROT:  cw = '{op: OP_ROT,  cond: C_LOOP,  target: ST_ROT};
			ST_RND:  cw = '{op: OP_RND,  cond: C_NEXT,  target: ST_CAL};
			ST_WRAP: cw = '{op: OP_WRAP, cond: C_RANGE, target: ST_WRAP};
			ST_DONE: cw = '{op: OP_NOP,  cond: C_END,   target: ST_CAL};
			default: cw = '{op: OP_NOP,  cond: C_END,   target: ST_CAL};
		endcase
		return cw;
	endfunction

	// atan(2^-i) in centidegrees * 65536
	function automatic logic signed [31:0] atan_z(logic [4:0] i);
		logic signed [31:0] v;
		case (i)
			5'd0:  v = 32'sd294912000;
			5'd1:  v = 32'sd174096719;
			5'd2:  v = 32'sd91987925;
			5'd3:  v = 32'sd46694507;
			5'd4:  v = 32'sd23437865;
			5'd5:  v = 32'sd11730358;
			5'd6:  v = 32'sd5866610;
			5'd7:  v = 32'sd2933484;
			5'd8:  v = 32'sd1466764;
			5'd9:  v = 32'sd733385;
			5'd10: v = 32'sd366693;
			5'd11: v = 32'sd183346;
			5'd12: v = 32'sd91673;
			5'd13: v = 32'sd45837;
			5'd14: v = 32'sd22918;
			5'd15: v = 32'sd11459;
			5'd16: v = 32'sd5730;
			5'd17: v = 32'sd2865;
			5'd18: v = 32'sd1432;
			5'd19: v = 32'sd716;
			5'd20: v = 32'sd358;
			5'd21: v = 32'sd179;
			5'd22: v = 32'sd90;
			5'd23: v = 32'sd45;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: design/cch_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module cch_datapath #(
	parameter int SAMPLE_BITS  = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          load,
	input  wire  [SAMPLE_BITS-1:0]       raw_x,
	input  wire  [SAMPLE_BITS-1:0]       raw_y,
	input  wire  [31:0]                  now_ms,
	input  wire  [15:0]                  decl,
	input  wire  [15:0]                  window,
	input  cch_pkg::ctrl_t               ctrl,
	output cch_pkg::status_t             status,
	output cch_pkg::res_t                res
);
	import cch_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int W  = SAMPLE_BITS + 10;
	localparam int IW = $clog2(CORDIC_STEPS);

	logic signed [SB-1:0] xs_q, ys_q;
	logic [31:0]          now_q, start_q;
	logic                 started_q, done_q, cal_q;
	logic signed [SB-1:0] max_x_q, min_x_q, max_y_q, min_y_q;
	logic signed [SB:0]   mid_x_q, mid_y_q;
	logic signed [W-1:0]  cx_q, cy_q;
	logic signed [31:0]   z_q;
	logic [IW-1:0]        i_q;
	logic signed [17:0]   s_q;

	logic [31:0]          elapsed;
	logic                 in_win;
	logic signed [W-1:0]  xw, yw, mxw, myw, cx_n, cy_n;
	logic signed [W-1:0]  dx, dy;
	logic signed [31:0]   z_rnd;
	logic signed [15:0]   ang;
	logic signed [17:0]   s_n;
	logic [15:0]          h;
	logic [2:0]           sec;

	assign elapsed = now_q - (started_q ? start_q : now_q);
	assign in_win  = elapsed < {16'd0, window};

	assign xw   = {{(W-SB){xs_q[SB-1]}}, xs_q};
	assign yw   = {{(W-SB){ys_q[SB-1]}}, ys_q};
	assign mxw  = {{(W-SB-1){mid_x_q[SB]}}, mid_x_q};
	assign myw  = {{(W-SB-1){mid_y_q[SB]}}, mid_y_q};
	assign cx_n = ((xw <<< 1) - mxw) <<< 6;
	assign cy_n = ((yw <<< 1) - myw) <<< 6;

	assign dx = cy_q >>> i_q;
	assign dy = cx_q >>> i_q;

	assign z_rnd = z_q + ROUND_HALF;
	assign ang   = z_rnd[31:16];
	assign s_n   = {{2{ang[15]}}, ang} + {{2{decl[15]}}, decl};

	assign status.vec_zero  = (cx_n == '0) && (cy_n == '0);
	assign status.iter_last = (i_q == IW'(CORDIC_STEPS - 1));
	assign status.out_range = s_q[17] || (s_q >= FULL_TURN);

	always_ff @(posedge clk) begin
		if (load) begin
			xs_q  <= raw_x;
			ys_q  <= raw_y;
			now_q <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			started_q <= 1'b0;
			done_q    <= 1'b0;
			cal_q     <= 1'b0;
			max_x_q   <= {1'b1, {(SB-1){1'b0}}};
			max_y_q   <= {1'b1, {(SB-1){1'b0}}};
			min_x_q   <= {1'b0, {(SB-1){1'b1}}};
			min_y_q   <= {1'b0, {(SB-1){1'b1}}};
			mid_x_q   <= '0;
			mid_y_q   <= '0;
		end else begin
			case (ctrl.op)
				OP_CAL: begin
					if (!started_q) begin
						start_q   <= now_q;
						started_q <= 1'b1;
					end
					cal_q <= 1'b0;
					if (!done_q) begin
						if (in_win) begin
							if (xs_q > max_x_q) max_x_q <= xs_q;
							if (xs_q < min_x_q) min_x_q <= xs_q;
							if (ys_q > max_y_q) max_y_q <= ys_q;
							if (ys_q < min_y_q) min_y_q <= ys_q;
							cal_q <= 1'b1;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				OP_MID: begin
					if (cal_q) begin
						mid_x_q <= {max_x_q[SB-1], max_x_q} + {min_x_q[SB-1], min_x_q};
						mid_y_q <= {max_y_q[SB-1], max_y_q} + {min_y_q[SB-1], min_y_q};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_VEC: begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				z_q  <= '0;
			end
			OP_PRE: begin
				i_q <= '0;
				// fold the left half plane onto the right one
				if (cx_q[W-1]) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
					z_q  <= HALF_TURN_Z;
				end
			end
			OP_ROT: begin
				i_q <= i_q + 1'b1;
				if (cy_q > 0) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					z_q  <= z_q + atan_z(5'(i_q));
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					z_q  <= z_q - atan_z(5'(i_q));
				end
			end
			OP_RND: s_q <= s_n;
			OP_WRAP: begin
				if (s_q[17]) s_q <= s_q + FULL_TURN;
				else if (s_q >= FULL_TURN) s_q <= s_q - FULL_TURN;
			end
			default: ;
		endcase
	end

	assign h = s_q[15:0];

	always_comb begin
		if (h > EDGE_N_HI || h < EDGE_N_LO) sec = SEC_N;
		else if (h > EDGE_NW) sec = SEC_NW;
		else if (h > EDGE_W)  sec = SEC_W;
		else if (h > EDGE_SW) sec = SEC_SW;
		else if (h > EDGE_S)  sec = SEC_S;
		else if (h > EDGE_SE) sec = SEC_SE;
		else if (h > EDGE_E)  sec = SEC_E;
		else sec = SEC_NE;
	end

	assign res.heading = h;
	assign res.sector  = sec;
	assign res.lamp    = (sec == SEC_N);
	assign res.cal     = cal_q;

endmodule
`default_nettype wire

FILE: design/calibrated_compass_heading.sv
`timescale 1ns / 1ps
`default_nettype none
// Compass heading from raw magnetometer X/Y with hard-iron calibration over a
// time window after the first sample. One item at a time: an item runs the
// calibration, midpoint, vectoring, fold, rotation, rounding and wrap steps in
// turn, and a zero corrected vector skips the fold and rotation; the shared
// CORDIC rotator does one step per cycle. A finished result sits in the output
// register, and the next item is taken while it waits. Configuration is taken
// at any time but must be written only while the block is idle.
module calibrated_compass_heading #(
	parameter int SAMPLE_BITS  = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [SAMPLE_BITS-1:0]         raw_x,
	input  wire  [SAMPLE_BITS-1:0]         raw_y,
	input  wire  [31:0]                    now_ms,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [15:0]                    heading_centideg,
	output logic [2:0]                     sector,
	output logic                           north_lamp,
	output logic                           calibrating,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [cch_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [15:0]                    cfg_data
);
	import cch_pkg::*;

	seq_state_t state_q, state_n;
	step_t      step_q, step_n;
	logic       out_valid_q;
	res_t       res_q;
	logic [15:0] decl_q, window_q;

	ctrl_t   cw, ctrl;
	status_t status;
	res_t    res;
	logic    accept, out_free, finish;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cw        = ucode(step_q);
	assign finish    = (state_q == SQ_RUN) && (cw.cond == C_END) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q   <= DECL_RESET;
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DECL:   decl_q   <= cfg_data;
				REG_WINDOW: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			SQ_IDLE: if (accept) state_n = SQ_RUN;
			SQ_RUN:  if (finish) state_n = SQ_IDLE;
			default: state_n = SQ_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q == SQ_RUN);
		ctrl     = (state_q == SQ_RUN) ? cw : ctrl_t'{op: OP_NOP, cond: C_END, target: ST_CAL};
	end

	// step sequencing from the control word's condition
	always_comb begin
		step_n = step_q;
		if (state_q == SQ_RUN) begin
			case (cw.cond)
				C_NEXT:  step_n = step_q + 1'b1;
				C_ZERO:  step_n = status.vec_zero ? cw.target : step_q + 1'b1;
				C_LOOP:  step_n = status.iter_last ? step_q + 1'b1 : cw.target;
				C_RANGE: step_n = status.out_range ? cw.target : step_q + 1'b1;
				C_END:   step_n = out_free ? ST_CAL : step_q;
				default: step_n = ST_CAL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			step_q      <= ST_CAL;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			step_q  <= step_n;
			if (finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) res_q <= res;
	end

	cch_datapath #(
		.SAMPLE_BITS  (SAMPLE_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.raw_x  (raw_x),
		.raw_y  (raw_y),
		.now_ms (now_ms),
		.decl   (decl_q),
		.window (window_q),
		.ctrl   (ctrl),
		.status (status),
		.res    (res)
	);

	assign out_valid        = out_valid_q;
	assign heading_centideg = res_q.heading;
	assign sector           = res_q.sector;
	assign north_lamp       = res_q.lamp;
	assign calibrating      = res_q.cal;

`ifndef ASSERT_OFF
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SQ_IDLE |-> step_q == ST_CAL)
		else $error("sequencer idle away from first step");

	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == SQ_RUN && step_q == ST_CAL)
		else $error("accepted item did not start the program");

	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid && heading_centideg < 16'd36000)
		else $error("finished item gave no valid heading");

	a_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> north_lamp == (sector == SEC_N))
		else $error("north lamp disagrees with sector");
`endif

endmodule
`default_nettype wire

FILE: dv/calibrated_compass_heading_tb.sv
`timescale 1ns / 1ps
module calibrated_compass_heading_tb;
	import cch_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_PRINTS = 40;
	localparam logic [31:0] T0 = 32'hFFFF_FF00;
	// atan(2^-i) in centidegrees * 65536
	localparam longint ATAN_STEP [16] = '{
		294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
		5866610, 2933484, 1466764, 733385, 366693, 183346,
		91673, 45837, 22918, 11459
	};

	typedef struct {
		bit                   is_reg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [15:0]          reg_val;
		logic [15:0]          x;
		logic [15:0]          y;
		logic [31:0]          t;
		bit                   typed;
		res_t                 want;
	} step_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid;
	logic                 in_stall;
	logic [15:0]          raw_x;
	logic [15:0]          raw_y;
	logic [31:0]          now_ms;
	logic                 out_valid;
	logic                 out_stall;
	logic [15:0]          heading_centideg;
	logic [2:0]           sector;
	logic                 north_lamp;
	logic                 calibrating;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	// predictor state
	logic signed [15:0] decl_reg = DECL_RESET;
	logic [15:0]        window_reg = WINDOW_RESET;
	logic signed [15:0] hi_x = -16'sd32767 - 16'sd1;
	logic signed [15:0] lo_x = 16'sd32767;
	logic signed [15:0] hi_y = -16'sd32767 - 16'sd1;
	logic signed [15:0] lo_y = 16'sd32767;
	logic signed [16:0] mid_x = '0;
	logic signed [16:0] mid_y = '0;
	logic [31:0]        t_start = '0;
	bit                 seen_first = 1'b0;
	bit                 cal_done = 1'b0;

	res_t pending_headings [$];
	int   n_samples = 0;
	int   n_checked = 0;
	int   n_writes = 0;
	int   n_mismatch = 0;
	int   burst_left = 0;
	int   stall_left = 0;
	logic stall_lvl = 1'b0;
	int   idle_cycles = 0;

	calibrated_compass_heading dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.raw_x            (raw_x),
		.raw_y            (raw_y),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.heading_centideg (heading_centideg),
		.sector           (sector),
		.north_lamp       (north_lamp),
		.calibrating      (calibrating),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int cordic_angle(logic signed [63:0] ay, logic signed [63:0] ax);
		logic signed [63:0] z;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		z = 0;
		if (ax == 0 && ay == 0)
			return 0;
		ax = ax * 64;
		ay = ay * 64;
		// fold the left half plane onto the right one
		if (ax < 0) begin
			ax = -ax;
			ay = -ay;
			z = 64'sd18000 * 64'sd65536;
		end
		for (int i = 0; i < 16; i++) begin
			dx = ay >>> i;
			dy = ax >>> i;
			if (ay > 0) begin
				ax = ax + dx;
				ay = ay - dy;
				z = z + ATAN_STEP[i];
			end else begin
				ax = ax - dx;
				ay = ay + dy;
				z = z - ATAN_STEP[i];
			end
		end
		return int'((z + 32768) >>> 16);
	endfunction

	function automatic res_t predict_heading(logic signed [15:0] x, logic signed [15:0] y,
			logic [31:0] t);
		res_t               r;
		logic [31:0]        elapsed;
		logic signed [63:0] vx;
		logic signed [63:0] vy;
		int                 h;
		logic [2:0]         sec;
		r = '0;
		if (!seen_first) begin
			t_start = t;
			seen_first = 1'b1;
		end
		elapsed = t - t_start;
		if (!cal_done) begin
			if (elapsed < {16'd0, window_reg}) begin
				if (x > hi_x) hi_x = x;
				if (x < lo_x) lo_x = x;
				if (y > hi_y) hi_y = y;
				if (y < lo_y) lo_y = y;
				mid_x = hi_x + lo_x;
				mid_y = hi_y + lo_y;
				r.cal = 1'b1;
			end else begin
				cal_done = 1'b1;
			end
		end
		vx = x;
		vy = y;
		vx = vx * 2 - mid_x;
		vy = vy * 2 - mid_y;
		h = (cordic_angle(vy, vx) + int'(decl_reg)) % 36000;
		if (h < 0)
			h += 36000;
		if (h > EDGE_N_HI || h < EDGE_N_LO) sec = SEC_N;
		else if (h > EDGE_NW) sec = SEC_NW;
		else if (h > EDGE_W) sec = SEC_W;
		else if (h > EDGE_SW) sec = SEC_SW;
		else if (h > EDGE_S) sec = SEC_S;
		else if (h > EDGE_SE) sec = SEC_SE;
		else if (h > EDGE_E) sec = SEC_E;
		else sec = SEC_NE;
		r.heading = 16'(h);
		r.sector = sec;
		r.lamp = (sec == SEC_N);
		return r;
	endfunction

	function automatic step_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
		step_row_t r;
		r = '{default: '0};
		r.is_reg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = 16'(val);
		return r;
	endfunction

	function automatic step_row_t sample_row(int x, int y, logic [31:0] t);
		step_row_t r;
		r = '{default: '0};
		r.x = 16'(x);
		r.y = 16'(y);
		r.t = t;
		return r;
	endfunction

	function automatic step_row_t known_row(int x, int y, logic [31:0] t, int h,
			logic [2:0] sec, bit cal);
		step_row_t r;
		r = sample_row(x, y, t);
		r.typed = 1'b1;
		r.want.heading = 16'(h);
		r.want.sector = sec;
		r.want.lamp = (sec == SEC_N);
		r.want.cal = cal;
		return r;
	endfunction

	// half full range, a quarter tiny values near zero, a quarter moderate swings
	function automatic logic [15:0] pick_axis();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 6) - 3);
			1: return 16'(int'($urandom_range(0, 6000)) - 3000);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		n_mismatch++;
		if (n_mismatch <= MAX_PRINTS)
			$display("%0t: %s got %0d, expected %0d (result %0d)", $time, field, got, want,
				n_checked);
	endtask

	task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [31:0] t,
			bit typed = 1'b0, res_t known = '0);
		res_t guess;
		int   gap;
		cfg_valid <= 1'b0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		raw_x <= x;
		raw_y <= y;
		now_ms <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_samples++;
		guess = predict_heading(x, y, t);
		pending_headings.push_back(typed ? known : guess);
	endtask

	task automatic drain_pending();
		in_valid <= 1'b0;
		while (pending_headings.size() != 0) @(posedge clk);
	endtask

	// leave valid high; the next sample drops it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		n_writes++;
		case (idx)
			REG_DECL: decl_reg = val;
			REG_WINDOW: window_reg = val;
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_lvl = ($urandom_range(0, 2) == 0);
			stall_left = stall_lvl ? $urandom_range(1, 40) : $urandom_range(1, 60);
		end else begin
			stall_left--;
		end
		out_stall <= stall_lvl;
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_headings.size() == 0) begin
				report_mismatch("result with nothing pending", heading_centideg, 0);
			end else begin
				want = pending_headings.pop_front();
				n_checked++;
				if (heading_centideg !== want.heading)
					report_mismatch("heading_centideg", heading_centideg, want.heading);
				if (sector !== want.sector)
					report_mismatch("sector", sector, want.sector);
				if (north_lamp !== want.lamp)
					report_mismatch("north_lamp", north_lamp, want.lamp);
				if (calibrating !== want.cal)
					report_mismatch("calibrating", calibrating, want.cal);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		step_row_t          plan [$];
		int                 sweep_dx [8];
		int                 sweep_dy [8];
		logic signed [15:0] decl_set [6];
		logic [15:0]        win_set [6];
		int                 el;
		int                 win_edge;
		in_valid = 1'b0;
		raw_x = '0;
		raw_y = '0;
		now_ms = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		// while the bounds hold a single point the corrected vector is zero,
		// so the heading is the declination alone
		plan.push_back(known_row(120, -340, T0, 255, SEC_N, 1'b1));
		plan.push_back(reg_row(REG_DECL, 2250));
		plan.push_back(known_row(120, -340, T0 + 1, 2250, SEC_NE, 1'b1));
		plan.push_back(reg_row(REG_DECL, -2250));
		plan.push_back(known_row(120, -340, T0 + 2, 33750, SEC_NW, 1'b1));
		plan.push_back(reg_row(REG_DECL, 2249));
		plan.push_back(known_row(120, -340, T0 + 3, 2249, SEC_N, 1'b1));
		plan.push_back(reg_row(REG_DECL, -2249));
		plan.push_back(known_row(120, -340, T0 + 4, 33751, SEC_N, 1'b1));
		plan.push_back(reg_row(REG_DECL, 32767));
		plan.push_back(known_row(120, -340, T0 + 5, 32767, SEC_NW, 1'b1));
		plan.push_back(reg_row(REG_DECL, -32768));
		plan.push_back(known_row(120, -340, T0 + 6, 3232, SEC_NE, 1'b1));
		plan.push_back(reg_row(REG_DECL, 18000));
		plan.push_back(known_row(120, -340, T0 + 7, 18000, SEC_S, 1'b1));
		plan.push_back(reg_row(REG_DECL, -18000));
		plan.push_back(known_row(120, -340, T0 + 8, 18000, SEC_S, 1'b1));
		plan.push_back(reg_row(REG_DECL, 0));
		plan.push_back(known_row(120, -340, T0 + 9, 0, SEC_N, 1'b1));
		// writes to unused indexes must leave both registers alone
		plan.push_back(reg_row(REG_SPARE_A, 16'h1234));
		plan.push_back(reg_row(REG_SPARE_B, 16'hFFFF));
		plan.push_back(known_row(120, -340, T0 + 10, 0, SEC_N, 1'b1));
		sweep_dx = '{1000, 700, 0, -700, -1000, -700, 0, 700};
		sweep_dy = '{0, 700, 1000, 700, 0, -700, -1000, -700};
		foreach (sweep_dx[k])
			plan.push_back(sample_row(120 + sweep_dx[k], -340 + sweep_dy[k], T0 + 20 + k));
		// extremes, time stamp wrapping past zero
		plan.push_back(sample_row(32767, -32768, 32'hFFFF_FFFF));
		plan.push_back(sample_row(-32768, 32767, 32'h0000_0000));
		plan.push_back(sample_row(0, 0, T0 + 300));
		// one below the window edge still tracks
		plan.push_back(sample_row(-1, -1, T0 + 4999));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				drain_pending();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_sample(plan[i].x, plan[i].y, plan[i].t, plan[i].typed, plan[i].want);
			end
		end

		// widest window, keep tracking
		drain_pending();
		write_reg(REG_WINDOW, 16'hFFFF);
		el = 5000;
		repeat (150) begin
			el += $urandom_range(0, 300);
			send_sample(pick_axis(), pick_axis(), T0 + el);
		end

		// close the window exactly on a sample, then confirm the latch holds
		drain_pending();
		win_edge = el + 40;
		write_reg(REG_WINDOW, 16'(win_edge));
		send_sample(pick_axis(), pick_axis(), T0 + win_edge - 1);
		send_sample(pick_axis(), pick_axis(), T0 + win_edge);
		send_sample(pick_axis(), pick_axis(), T0 + win_edge - 5);

		decl_set = '{-16'sd18000, 16'sd18000, 16'sd32767, 16'sh8000, 16'sd0, 16'sd255};
		decl_set[4] = 16'(int'($urandom_range(0, 36000)) - 18000);
		win_set = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd0, 16'd5000};
		for (int k = 0; k < 6; k++) begin
			drain_pending();
			write_reg(REG_DECL, decl_set[k]);
			write_reg(REG_WINDOW, win_set[k]);
			repeat (60)
				send_sample(pick_axis(), pick_axis(), $urandom);
		end

		drain_pending();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("compass run: %0d samples sent, %0d headings compared, %0d register writes",
			n_samples, n_checked, n_writes);
		$display("covered: bound tracking, window edge and latch, zero vector, sector edges, "
			, "declination wrap");
		if (n_mismatch == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
